[design/fbm_pkg.sv]
// ----------------------------------------------------------------------------
// fbm_pkg: shared types and constants of the frequency bandlimit mask
// Request payload types, register indexes, mode codes, fixed-point constants
// and the reciprocal tables of the exponential series.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbm_pkg;

  localparam int MAX_SIZE_LOG2    = 10;
  localparam int WEIGHT_FRAC_BITS = 40;
  localparam int IDX_W            = 10;
  localparam int SCALE_W          = 48;
  localparam int WEIGHT_W         = WEIGHT_FRAC_BITS + 1;
  localparam int CFG_IDX_W        = 3;

  typedef struct packed {
    logic [IDX_W-1:0] col_index;
    logic [IDX_W-1:0] row_index;
  } mask_in_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                mode_error;
  } mask_out_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_LOG2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_LOG2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y   = 3'd4;

  // mode codes; the spare code behaves as disabled
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_SHARP  = 2'd1;
  localparam logic [1:0] MODE_SMOOTH = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  // squared radius, unsigned Q.48 saturated at 16.0
  localparam int         RS_W        = 53;
  localparam logic [52:0] RS_CAP     = 53'h10_0000_0000_0000;
  // 4.0 in Q.48, compared against 9*rs
  localparam logic [56:0] SHARP_LIMIT = 57'h4_0000_0000_0000;

  localparam int SQRT_STEPS     = (RS_W + 1) / 2;
  localparam int SQRT_PER_STAGE = 3;
  localparam int SQRT_STAGES    = (SQRT_STEPS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
  localparam int ROOT_W         = SQRT_STEPS;

  // Fermi center 37/60 in Q.24, and the offset at which the exponent reaches 40
  localparam logic [26:0] MU_Q24 = 27'd10345950;
  localparam logic [26:0] BIG_AD = 27'd10066330;
  localparam logic [31:0] DIV3_MAGIC = 32'hAAAA_AAAB;
  localparam logic [31:0] ONE_Q31    = 32'h8000_0000;

  localparam int HORNER_TERMS  = 12;
  localparam int EXP_SQUARINGS = 6;

  localparam int DIV_PER_STAGE = 3;
  localparam int DIV_STAGES    = (WEIGHT_FRAC_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  // ceil(2^(31+L)/n) with L = ceil(log2 n): exact floor(m/n) for m below 2^31
  function automatic logic [31:0] horner_magic(input int n);
    logic [31:0] m;
    m = 32'h8000_0000;
    case (n)
      3, 6, 12: m = 32'd2863311531;
      5, 10:    m = 32'd3435973837;
      7:        m = 32'd2454267027;
      9:        m = 32'd3817748708;
      11:       m = 32'd3123612579;
      default:  m = 32'h8000_0000;
    endcase
    return m;
  endfunction

  function automatic int horner_shift(input int n);
    int s;
    s = 31;
    case (n)
      2:                    s = 32;
      3, 4:                 s = 33;
      5, 6, 7, 8:           s = 34;
      9, 10, 11, 12:        s = 35;
      default:              s = 31;
    endcase
    return s;
  endfunction

endpackage

[design/frequency_bandlimit_mask.sv]
// ----------------------------------------------------------------------------
// frequency_bandlimit_mask: low-pass weight for one FFT-grid pixel
// Takes a column/row index pair of a 2^cols_log2 by 2^rows_log2 grid in FFT
// order and returns its bandlimit weight divided by the pixel count, with 40
// fractional bits. Sharp mode cuts off above a normalized radius of 2/3;
// smooth mode applies a Fermi roll-off centered at 37/60 with width 0.015.
// The block accepts one request per clock while in_ready is high and returns
// one result per request, in order. The depth is set by the square root
// (three digits per stage), the twelve-term exponential series (a multiply
// stage and a reciprocal stage per term), six squaring stages and the
// restoring divider (three quotient bits per stage). A two-entry output
// queue lets the pipeline keep advancing while a result waits, so in_ready
// drops only when both entries are occupied. Registers are written through
// cfg_wr_en / cfg_index / cfg_data and must only change while no request is
// in flight. Disabled mode and the unused mode code return weight 0 with
// mode_error set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frequency_bandlimit_mask (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fbm_pkg::mask_in_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fbm_pkg::mask_out_t                  out_data,
  input  logic                                cfg_wr_en,
  input  logic [fbm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fbm_pkg::SCALE_W-1:0]         cfg_data
);

  localparam int W     = fbm_pkg::WEIGHT_FRAC_BITS;
  localparam int WW    = fbm_pkg::WEIGHT_W;
  localparam int SQ    = fbm_pkg::SQRT_STAGES;
  localparam int HT    = fbm_pkg::HORNER_TERMS;
  localparam int ES    = fbm_pkg::EXP_SQUARINGS;
  localparam int DV    = fbm_pkg::DIV_STAGES;
  // front end 5, root, offset 3, series 2 per term, squarings, prep 1, divide, output 1
  localparam int LAT   = 5 + SQ + 3 + 2 * HT + ES + 1 + DV + 1;

  typedef struct packed {
    logic over;
    logic neg;
    logic big;
  } flags_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]                  mode;
  logic [3:0]                  cols_log2;
  logic [3:0]                  rows_log2;
  logic [fbm_pkg::SCALE_W-1:0] scale_x;
  logic [fbm_pkg::SCALE_W-1:0] scale_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= fbm_pkg::MODE_SHARP;
      cols_log2 <= 4'd8;
      rows_log2 <= 4'd8;
      scale_x   <= 48'd17179869184;
      scale_y   <= 48'd17179869184;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fbm_pkg::REG_MODE:      mode      <= cfg_data[1:0];
        fbm_pkg::REG_COLS_LOG2: cols_log2 <= cfg_data[3:0];
        fbm_pkg::REG_ROWS_LOG2: rows_log2 <= cfg_data[3:0];
        fbm_pkg::REG_SCALE_X:   scale_x   <= cfg_data;
        fbm_pkg::REG_SCALE_Y:   scale_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp grid sizes to the supported maximum
  logic [3:0] lc, lr;
  logic [4:0] shift_k;
  assign lc = (cols_log2 > 4'(fbm_pkg::MAX_SIZE_LOG2)) ? 4'(fbm_pkg::MAX_SIZE_LOG2)
                                                       : cols_log2;
  assign lr = (rows_log2 > 4'(fbm_pkg::MAX_SIZE_LOG2)) ? 4'(fbm_pkg::MAX_SIZE_LOG2)
                                                       : rows_log2;
  assign shift_k = 5'(lc) + 5'(lr);

  // --------------------------------------------------------------------------
  // Flow control: the whole pipeline advances while the output queue has room
  // --------------------------------------------------------------------------
  logic           adv;
  logic [LAT-1:0] vld;
  logic [1:0]     count;
  logic           push, pop;

  assign adv      = (count != 2'd2);
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // --------------------------------------------------------------------------
  // Front end: frequency magnitude, squares, scaling, squared radius
  // --------------------------------------------------------------------------
  function automatic logic [9:0] freq_mag(input logic [9:0] idx, input logic [3:0] lg);
    logic [10:0] size;
    logic [10:0] i;
    size = 11'(1) << lg;
    i    = {1'b0, idx} & (size - 11'd1);
    if (i > (size >> 1)) begin
      freq_mag = 10'(size - i);
    end else begin
      freq_mag = 10'(i);
    end
  endfunction

  function automatic logic [52:0] sat_term(input logic [43:0] hi, input logic [43:0] lo);
    logic [67:0] full;
    full = {hi, 24'b0} + 68'(lo);
    if (full > 68'(fbm_pkg::RS_CAP)) begin
      sat_term = fbm_pkg::RS_CAP;
    end else begin
      sat_term = full[52:0];
    end
  endfunction

  logic [9:0]  kx, ky;
  logic [19:0] kx2, ky2;
  logic [43:0] px_lo, px_hi, py_lo, py_hi;
  logic [52:0] tx, ty;
  logic [52:0] rs;
  logic [53:0] rs_sum;
  logic        rs_over;

  assign rs_sum  = 54'(tx) + 54'(ty);
  assign rs_over = ((57'(rs) << 3) + 57'(rs)) > fbm_pkg::SHARP_LIMIT;

  always_ff @(posedge clk) begin
    if (adv) begin
      kx    <= freq_mag(in_data.col_index, lc);
      ky    <= freq_mag(in_data.row_index, lr);
      kx2   <= 20'(kx) * 20'(kx);
      ky2   <= 20'(ky) * 20'(ky);
      // split the 48-bit scale so each product stays narrow
      px_lo <= 44'(kx2) * 44'(scale_x[23:0]);
      px_hi <= 44'(kx2) * 44'(scale_x[47:24]);
      py_lo <= 44'(ky2) * 44'(scale_y[23:0]);
      py_hi <= 44'(ky2) * 44'(scale_y[47:24]);
      tx    <= sat_term(px_hi, px_lo);
      ty    <= sat_term(py_hi, py_lo);
      rs    <= (rs_sum > 54'(fbm_pkg::RS_CAP)) ? fbm_pkg::RS_CAP : rs_sum[52:0];
    end
  end

  // --------------------------------------------------------------------------
  // Square root: digit recurrence, three digits per stage
  // --------------------------------------------------------------------------
  logic [53:0] sq_v [SQ];
  logic [53:0] sq_r [SQ];
  logic        sq_o [SQ];

  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    logic [53:0] v_in, r_in, v_nx, r_nx;
    logic        o_in;
    if (g == 0) begin : g_first
      assign v_in = 54'(rs);
      assign r_in = '0;
      assign o_in = rs_over;
    end else begin : g_rest
      assign v_in = sq_v[g-1];
      assign r_in = sq_r[g-1];
      assign o_in = sq_o[g-1];
    end

    always_comb begin
      logic [53:0] bitv;
      logic [53:0] trial;
      bitv  = '0;
      trial = '0;
      v_nx  = v_in;
      r_nx  = r_in;
      for (int j = 0; j < fbm_pkg::SQRT_PER_STAGE; j++) begin
        if (g * fbm_pkg::SQRT_PER_STAGE + j < fbm_pkg::SQRT_STEPS) begin
          bitv  = 54'(1) << (2 * (fbm_pkg::SQRT_STEPS - 1)
                             - 2 * (g * fbm_pkg::SQRT_PER_STAGE + j));
          trial = r_nx + bitv;
          if (v_nx >= trial) begin
            v_nx = v_nx - trial;
            r_nx = (r_nx >> 1) + bitv;
          end else begin
            r_nx = r_nx >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_v[g] <= v_nx;
        sq_r[g] <= r_nx;
        sq_o[g] <= o_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Offset from the Fermi center and exponent argument u = 2*|r-mu|*200/3
  // --------------------------------------------------------------------------
  logic [26:0] root, ad_c;
  logic        neg_c;
  logic [26:0] ad1;
  flags_t      f1, f2, f3;
  logic [31:0] x2;
  logic [31:0] u3;
  logic [63:0] div3_prod;

  assign root      = sq_r[SQ-1][26:0];
  assign neg_c     = root < fbm_pkg::MU_Q24;
  assign ad_c      = neg_c ? (fbm_pkg::MU_Q24 - root) : (root - fbm_pkg::MU_Q24);
  assign div3_prod = 64'(x2) * 64'(fbm_pkg::DIV3_MAGIC);

  always_ff @(posedge clk) begin
    if (adv) begin
      ad1     <= ad_c;
      f1.over <= sq_o[SQ-1];
      f1.neg  <= neg_c;
      // beyond this offset the exponential term underflows to zero
      f1.big  <= ad_c >= fbm_pkg::BIG_AD;
      x2      <= 32'(ad1) * 32'd200;
      f2      <= f1;
      u3      <= {div3_prod[63:33], 1'b0};
      f3      <= f2;
    end
  end

  // --------------------------------------------------------------------------
  // exp(-u) series by Horner: multiply stage, then reciprocal divide stage
  // --------------------------------------------------------------------------
  logic [31:0] hm_u [HT];
  logic [30:0] hm_m [HT];
  flags_t      hm_f [HT];
  logic [31:0] hd_u [HT];
  logic [31:0] hd_p [HT];
  flags_t      hd_f [HT];

  for (genvar h = 0; h < HT; h++) begin : g_horner
    localparam logic [31:0] MAG = fbm_pkg::horner_magic(HT - h);
    localparam int          SH  = fbm_pkg::horner_shift(HT - h);
    logic [31:0] u_in, p_in;
    flags_t      f_in;
    logic [63:0] up, mq;
    if (h == 0) begin : g_first
      assign u_in = u3;
      assign p_in = fbm_pkg::ONE_Q31;
      assign f_in = f3;
    end else begin : g_rest
      assign u_in = hd_u[h-1];
      assign p_in = hd_p[h-1];
      assign f_in = hd_f[h-1];
    end

    assign up = 64'(u_in) * 64'(p_in);
    assign mq = (64'(hm_m[h]) * 64'(MAG)) >> SH;

    always_ff @(posedge clk) begin
      if (adv) begin
        hm_u[h] <= u_in;
        hm_m[h] <= up[61:31];
        hm_f[h] <= f_in;
        hd_u[h] <= hm_u[h];
        hd_p[h] <= fbm_pkg::ONE_Q31 - mq[31:0];
        hd_f[h] <= hm_f[h];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Raise to the 64th power: six squarings, rounding half up in Q.31
  // --------------------------------------------------------------------------
  logic [31:0] es_p [ES];
  flags_t      es_f [ES];

  for (genvar e = 0; e < ES; e++) begin : g_square
    logic [31:0] p_in;
    flags_t      f_in;
    logic [63:0] pp;
    if (e == 0) begin : g_first
      assign p_in = hd_p[HT-1];
      assign f_in = hd_f[HT-1];
    end else begin : g_rest
      assign p_in = es_p[e-1];
      assign f_in = es_f[e-1];
    end

    assign pp = 64'(p_in) * 64'(p_in) + 64'h4000_0000;

    always_ff @(posedge clk) begin
      if (adv) begin
        es_p[e] <= pp[62:31];
        es_f[e] <= f_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider setup: numerator 1 or Y, denominator 1 + Y
  // --------------------------------------------------------------------------
  logic [31:0] y_c;
  logic [33:0] dp_rem;
  logic [32:0] dp_den;
  flags_t      dp_f;

  assign y_c = es_f[ES-1].big ? '0 : es_p[ES-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dp_den <= 33'(fbm_pkg::ONE_Q31) + 33'(y_c);
      dp_rem <= es_f[ES-1].neg ? 34'(fbm_pkg::ONE_Q31) : 34'(y_c);
      dp_f   <= es_f[ES-1];
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider, three quotient bits per stage, full fraction width
  // --------------------------------------------------------------------------
  logic [33:0]  dv_rem [DV];
  logic [32:0]  dv_den [DV];
  logic [W-1:0] dv_q   [DV];
  flags_t       dv_f   [DV];

  for (genvar d = 0; d < DV; d++) begin : g_div
    logic [33:0]  rem_in, rem_nx;
    logic [32:0]  den_in;
    logic [W-1:0] q_in, q_nx;
    flags_t       f_in;
    if (d == 0) begin : g_first
      assign rem_in = dp_rem;
      assign den_in = dp_den;
      assign q_in   = '0;
      assign f_in   = dp_f;
    end else begin : g_rest
      assign rem_in = dv_rem[d-1];
      assign den_in = dv_den[d-1];
      assign q_in   = dv_q[d-1];
      assign f_in   = dv_f[d-1];
    end

    always_comb begin
      rem_nx = rem_in;
      q_nx   = q_in;
      for (int j = 0; j < fbm_pkg::DIV_PER_STAGE; j++) begin
        if (d * fbm_pkg::DIV_PER_STAGE + j < W) begin
          rem_nx = rem_nx << 1;
          q_nx   = q_nx << 1;
          if (rem_nx >= 34'(den_in)) begin
            rem_nx  = rem_nx - 34'(den_in);
            q_nx[0] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[d] <= rem_nx;
        dv_den[d] <= den_in;
        dv_q[d]   <= q_nx;
        dv_f[d]   <= f_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: select by mode, scale down by the pixel count
  // --------------------------------------------------------------------------
  fbm_pkg::mask_out_t res_c, out_r;

  always_comb begin
    res_c.weight     = '0;
    res_c.mode_error = 1'b0;
    case (mode)
      fbm_pkg::MODE_SHARP: begin
        res_c.weight = dv_f[DV-1].over ? '0 : ((WW'(1) << W) >> shift_k);
      end
      fbm_pkg::MODE_SMOOTH: begin
        res_c.weight = WW'(dv_q[DV-1] >> shift_k);
      end
      default: begin
        res_c.mode_error = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res_c;
    end
  end

  // --------------------------------------------------------------------------
  // Two-entry output queue: hold results while the consumer stalls
  // --------------------------------------------------------------------------
  fbm_pkg::mask_out_t oq [2];
  logic               wr_ptr, rd_ptr;
  logic [1:0]         count_next;

  assign push      = adv & vld[LAT-1];
  assign pop       = out_valid & out_ready;
  assign out_valid = (count != 2'd0);
  assign out_data  = oq[rd_ptr];

  always_comb begin
    count_next = count;
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      oq[wr_ptr] <= out_r;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (vld == '0 && count == 2'd0))
    else $error("pipeline or queue not empty after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved while the output queue was full");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.mode_error |-> out_data.weight == '0)
    else $error("nonzero weight with mode error");

  a_weight_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.weight <= (WW'(1) << W))
    else $error("weight above one");

  a_sharp_pow2: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == fbm_pkg::MODE_SHARP |-> $countones(out_data.weight) <= 1)
    else $error("sharp weight is not zero or a power of two");

endmodule
